// File: rtl/core/mfq_pkg.sv
// Shared types and constants of the three-level feedback scheduler.
// Used by multilevel_feedback_queue_scheduler_unit; depends on nothing.
`default_nettype none

package mfq_pkg;

  localparam int NUM_LEVELS = 3;
  localparam int LEVEL_W    = 2;
  localparam int ID_W       = 4;
  localparam int TIME_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int REG_IDX_W  = 2;

  localparam int BURST_SLOTS        = 3;
  localparam int BURSTS_PER_PROGRAM = 3;
  localparam logic [1:0] MAX_BURST_IDX = 2'(BURST_SLOTS - 1);
  localparam logic [1:0] LAST_BURST =
    2'(((BURSTS_PER_PROGRAM < BURST_SLOTS) ? BURSTS_PER_PROGRAM : BURST_SLOTS) - 1);

  localparam logic [LEVEL_W-1:0] TOP_LEVEL    = 2'd0;
  localparam logic [LEVEL_W-1:0] MID_LEVEL    = 2'd1;
  localparam logic [LEVEL_W-1:0] BOTTOM_LEVEL = 2'd2;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PREEMPTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RETIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_QUANTUM0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUANTUM1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUANTUM2 = 2'd2;

  localparam logic [TIME_W-1:0] QUANTUM0_RESET = 8'd1;
  localparam logic [TIME_W-1:0] QUANTUM1_RESET = 8'd2;
  localparam logic [TIME_W-1:0] QUANTUM2_RESET = 8'd4;

  typedef struct packed {
    logic                cmd;
    logic [ID_W-1:0]     program_id;
    logic [TIME_W-1:0]   first_burst;
    logic [TIME_W-1:0]   second_burst;
    logic [TIME_W-1:0]   third_burst;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic [LEVEL_W-1:0]  from_level;
    logic [LEVEL_W-1:0]  to_level;
    logic [1:0]          burst_index;
    logic [TIME_W-1:0]   time_used;
    logic [TIME_W-1:0]   time_left;
  } out_t;

  // One queued program: identifier, burst in progress and the three burst times.
  typedef struct packed {
    logic [ID_W-1:0]                     id;
    logic [1:0]                          idx;
    logic [BURST_SLOTS-1:0][TIME_W-1:0]  burst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: rtl/core/multilevel_feedback_queue_scheduler_unit.sv
// Top level of the three-level feedback queue scheduler: sequencer, ring bookkeeping,
// quantum registers and result register. Depends on mfq_pkg and mfq_ram.
//
//   Channel   Signals                              Direction
//   in        in_valid, in_ready, in_data (in_t)   command words in
//   out       out_valid, out_ready, out_data       result words out
//   cfg       cfg_valid, cfg_ready, cfg_index,     quantum register writes
//             cfg_data
//
// A load word goes from acceptance through the hand-over step before the block is ready again.
// A dispatch word is accepted, then passes the level sweep (one level looked at per cycle),
// the ring RAM read, the compare of the burst with the quantum on the shared subtractor
// together with the requeue, and the hand-over.
// Reset is synchronous and empties all levels at once through the counts; no clearing pass.
// The result register frees the core, so a new word is taken while a result still waits;
// the core stalls in its hand-over step only while the previous result is not taken.
`default_nettype none

module multilevel_feedback_queue_scheduler_unit #(
  parameter int MAX_PROGRAMS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mfq_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mfq_pkg::out_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mfq_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [mfq_pkg::TIME_W-1:0]      cfg_data
);

  localparam int PW = $clog2(MAX_PROGRAMS);
  localparam int CW = $clog2(MAX_PROGRAMS + 1);
  localparam int SW = CW + 1;
  localparam int NL = mfq_pkg::NUM_LEVELS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SELECT = 4'b0010,
    S_EXEC   = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [PW-1:0]                    head_r   [NL];
  logic [PW-1:0]                    head_nxt [NL];
  logic [CW-1:0]                    count_r  [NL];
  logic [CW-1:0]                    count_nxt[NL];
  logic [mfq_pkg::TIME_W-1:0]       quant_r  [NL];
  logic [mfq_pkg::TIME_W-1:0]       quant_nxt[NL];
  logic [mfq_pkg::LEVEL_W-1:0]      cur_r, cur_nxt;
  logic [CW-1:0]                    pass_r, pass_nxt;
  logic [CW-1:0]                    loaded_r, loaded_nxt;
  mfq_pkg::out_t                    res_r, res_nxt;
  mfq_pkg::out_t                    out_data_r;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_load;

  logic                             ram_we;
  logic [mfq_pkg::LEVEL_W-1:0]      ram_wr_lvl;
  logic [PW-1:0]                    ram_wr_addr;
  mfq_pkg::entry_t                  ram_wr_data;
  logic                             ram_rd_en;
  logic [PW-1:0]                    ram_rd_addr;
  logic [mfq_pkg::ENTRY_W-1:0]      ram_rd_data [NL];

  mfq_pkg::entry_t                  ent;
  logic [1:0]                       bsel;
  logic [mfq_pkg::TIME_W-1:0]       rem;
  logic [mfq_pkg::TIME_W-1:0]       quant;
  logic [mfq_pkg::TIME_W:0]         diff;
  logic                             preempt;
  logic [mfq_pkg::LEVEL_W-1:0]      to_lvl;
  logic                             push;
  logic [CW+1:0]                    count_sum;

  // Position (h + c) modulo the ring depth; h < depth and c <= depth.
  function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(MAX_PROGRAMS)) begin
      s = s - SW'(MAX_PROGRAMS);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [mfq_pkg::LEVEL_W-1:0] next_level(
    input logic [mfq_pkg::LEVEL_W-1:0] l
  );
    return (l == mfq_pkg::BOTTOM_LEVEL) ? mfq_pkg::TOP_LEVEL : l + 2'd1;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  genvar g;
  generate
    for (g = 0; g < NL; g++) begin : g_ring
      mfq_ram #(
        .WIDTH (mfq_pkg::ENTRY_W),
        .DEPTH (MAX_PROGRAMS)
      ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we && (ram_wr_lvl == mfq_pkg::LEVEL_W'(g))),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data[g])
      );
    end
  endgenerate

  // The shared compare/subtract unit: the burst in progress against the level's quantum.
  always_comb begin
    ent     = mfq_pkg::entry_t'(ram_rd_data[cur_r]);
    bsel    = (ent.idx > mfq_pkg::MAX_BURST_IDX) ? mfq_pkg::MAX_BURST_IDX : ent.idx;
    rem     = ent.burst[bsel];
    quant   = quant_r[cur_r];
    diff    = {1'b0, rem} - {1'b0, quant};
    preempt = !diff[mfq_pkg::TIME_W] && (diff[mfq_pkg::TIME_W-1:0] != '0);
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    quant_nxt   = quant_r;
    cur_nxt     = cur_r;
    pass_nxt    = pass_r;
    loaded_nxt  = loaded_r;
    res_nxt     = res_r;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_wr_lvl  = mfq_pkg::TOP_LEVEL;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = head_r[cur_r];
    to_lvl      = mfq_pkg::TOP_LEVEL;
    push        = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfq_pkg::REG_QUANTUM0: quant_nxt[0] = cfg_data;
        mfq_pkg::REG_QUANTUM1: quant_nxt[1] = cfg_data;
        mfq_pkg::REG_QUANTUM2: quant_nxt[2] = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt           = '0;
          res_nxt.served_id = in_data.program_id;
          state_nxt         = S_FIN;
          if (in_data.cmd == mfq_pkg::CMD_LOAD) begin
            if (loaded_r >= CW'(MAX_PROGRAMS)) begin
              res_nxt.status = mfq_pkg::ST_FULL;
            end else begin
              ram_we                = 1'b1;
              ram_wr_lvl            = mfq_pkg::TOP_LEVEL;
              ram_wr_addr           = wrap_pos(head_r[0], count_r[0]);
              ram_wr_data.id        = in_data.program_id;
              ram_wr_data.idx       = 2'd0;
              ram_wr_data.burst[0]  = in_data.first_burst;
              ram_wr_data.burst[1]  = in_data.second_burst;
              ram_wr_data.burst[2]  = in_data.third_burst;
              count_nxt[0]          = count_r[0] + CW'(1);
              loaded_nxt            = loaded_r + CW'(1);
              res_nxt.status        = mfq_pkg::ST_LOADED;
              res_nxt.time_left     = in_data.first_burst;
            end
          end else if (loaded_r == '0) begin
            // Every queued program is counted in exactly one level.
            res_nxt.status    = mfq_pkg::ST_IDLE;
            res_nxt.served_id = '0;
            cur_nxt           = mfq_pkg::TOP_LEVEL;
            pass_nxt          = '0;
          end else begin
            if (pass_r > count_r[cur_r]) begin
              pass_nxt = count_r[cur_r];
            end
            state_nxt = S_SELECT;
          end
        end
      end

      S_SELECT: begin
        if (pass_r == '0) begin
          if (count_r[cur_r] != '0) begin
            pass_nxt = count_r[cur_r];
          end else begin
            cur_nxt = next_level(cur_r);
          end
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        head_nxt[cur_r]  = wrap_pos(head_r[cur_r], CW'(1));
        count_nxt[cur_r] = count_r[cur_r] - CW'(1);
        ram_wr_data      = ent;
        res_nxt.served_id   = ent.id;
        res_nxt.from_level  = cur_r;
        res_nxt.burst_index = bsel;
        if (preempt) begin
          ram_wr_data.burst[bsel] = diff[mfq_pkg::TIME_W-1:0];
          to_lvl                  = (cur_r == mfq_pkg::BOTTOM_LEVEL) ?
                                    mfq_pkg::BOTTOM_LEVEL : cur_r + 2'd1;
          push                    = 1'b1;
          res_nxt.status          = mfq_pkg::ST_PREEMPTED;
          res_nxt.time_used       = quant;
          res_nxt.time_left       = diff[mfq_pkg::TIME_W-1:0];
        end else begin
          ram_wr_data.burst[bsel] = '0;
          res_nxt.time_used       = rem;
          res_nxt.time_left       = '0;
          if (bsel >= mfq_pkg::LAST_BURST) begin
            res_nxt.status = mfq_pkg::ST_RETIRED;
            to_lvl         = mfq_pkg::TOP_LEVEL;
            if (loaded_r != '0) begin
              loaded_nxt = loaded_r - CW'(1);
            end
          end else begin
            res_nxt.status  = mfq_pkg::ST_DONE;
            ram_wr_data.idx = bsel + 2'd1;
            to_lvl          = (cur_r == mfq_pkg::TOP_LEVEL) ?
                              mfq_pkg::TOP_LEVEL : cur_r - 2'd1;
            push            = 1'b1;
          end
        end
        res_nxt.to_level = to_lvl;
        // The tail is taken after the pop, so a program rotating in its own level
        // lands behind the ones still waiting there.
        if (push) begin
          ram_we            = 1'b1;
          ram_wr_lvl        = to_lvl;
          ram_wr_addr       = wrap_pos(head_nxt[to_lvl], count_nxt[to_lvl]);
          count_nxt[to_lvl] = count_nxt[to_lvl] + CW'(1);
        end
        pass_nxt = pass_r - CW'(1);
        if (pass_r == CW'(1)) begin
          cur_nxt = next_level(cur_r);
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '{default: '0};
      count_r     <= '{default: '0};
      quant_r     <= '{mfq_pkg::QUANTUM0_RESET, mfq_pkg::QUANTUM1_RESET,
                       mfq_pkg::QUANTUM2_RESET};
      cur_r       <= mfq_pkg::TOP_LEVEL;
      pass_r      <= '0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      quant_r     <= quant_nxt;
      cur_r       <= cur_nxt;
      pass_r      <= pass_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign count_sum = (CW+2)'(count_r[0]) + (CW+2)'(count_r[1]) + (CW+2)'(count_r[2]);

  // Between words, the level counts add up to the number of programs present.
  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_sum == (CW+2)'(loaded_r)))
    else $error("level counts do not add up to the programs present");

  // The level sweep is only entered with at least one program queued.
  a_sweep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SELECT) |-> (loaded_r != '0))
    else $error("level sweep started with no program present");

  // A pop only happens from a level that holds a program and has dispatches left.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (pass_r != '0 && count_r[cur_r] != '0 && pass_r <= count_r[cur_r]))
    else $error("dispatch popped an empty level or an exhausted pass");

  // A finished result is handed over only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: rtl/core/mfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds one ring of queued programs; no package dependency.
`default_nettype none

module mfq_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
